/* hdl/mlt_pkg.sv */
// Package for the MAC learning table: payload structs, command codes,
// status codes and the controller/datapath interface structs.
// No dependencies.
package mlt_pkg;

    localparam int DEFAULT_ENTRIES = 64;
    localparam logic [15:0] MAX_AGE_RESET = 16'd300;

    localparam logic [2:0] CMD_LOOKUP = 3'd0;
    localparam logic [2:0] CMD_LEARN  = 3'd1;
    localparam logic [2:0] CMD_FLUSH  = 3'd2;
    localparam logic [2:0] CMD_SWEEP  = 3'd3;
    localparam logic [2:0] CMD_TICK   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [31:0] PORT_ALL = 32'hFFFF_FFFF;
    localparam logic [6:0]  REMOVED_MAX = 7'd127;

    // Byte address of the max_age register
    localparam logic [1:0] REG_MAX_AGE = 2'd0;

    typedef struct packed {
        logic [2:0]  command;
        logic [47:0] mac;
        logic [31:0] port;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] found_port;
        logic [31:0] learned_at;
        logic [1:0]  status;
        logic [6:0]  removed;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture request, clear scan state
        logic step;      // examine the slot at the scan index
        logic finish;    // resolve the request and write back
        logic tick;      // advance seconds
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;      // scan index at final slot
        logic stop;      // learn/lookup found its match, scan can end
    } dp_sts_t;

endpackage

/* hdl/mlt_ctrl.sv */
// Controller for the MAC learning table: handshake and scan sequencing.
// Depends on mlt_pkg.
module mlt_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       in_command,
    output logic             out_valid,
    input  logic             out_ready,
    output mlt_pkg::dp_cmd_t cmd,
    input  mlt_pkg::dp_sts_t sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = ovalid_reg;

    // Sequence: load, walk slots, resolve
    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (in_command == mlt_pkg::CMD_TICK)
                        cmd.tick = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.last || sts.stop)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish  = 1'b1;
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

/* hdl/mlt_dp.sv */
// Datapath for the MAC learning table: slot memories, scan compare,
// seconds counter and result register. Depends on mlt_pkg.
module mlt_dp
#(
    parameter int ENTRIES = mlt_pkg::DEFAULT_ENTRIES
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  mlt_pkg::req_t    req,
    input  logic [15:0]      max_age,
    input  mlt_pkg::dp_cmd_t cmd,
    output mlt_pkg::dp_sts_t sts,
    output mlt_pkg::rsp_t    rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Slot stores: valid bits in flops, payload in arrays
    logic [ENTRIES-1:0] valid_reg;
    logic [47:0] mac_mem   [ENTRIES];
    logic [31:0] port_mem  [ENTRIES];
    logic [31:0] stamp_mem [ENTRIES];

    mlt_pkg::req_t req_reg;
    logic [IW-1:0] idx_reg;
    logic [31:0]   now_reg;
    logic          match_reg;
    logic [IW-1:0] match_idx_reg;
    logic [31:0]   m_port_reg;
    logic [31:0]   m_stamp_reg;
    logic          free_reg;
    logic [IW-1:0] free_idx_reg;
    logic [6:0]    removed_reg;
    mlt_pkg::rsp_t rsp_reg;
    mlt_pkg::rsp_t rsp_next;
    logic [47:0]   slot_mac_reg;
    logic [31:0]   slot_port_reg;
    logic [31:0]   slot_stamp_reg;

    logic [IW-1:0] rd_addr;
    logic        last_slot;
    logic        stop_scan;
    logic        slot_v;
    logic [31:0] age;
    logic        aged;
    logic        mac_eq;
    logic        drop;
    logic        bad_mac;
    logic        m_aged;
    logic        learn_ok;
    logic        learn_move;
    logic        learn_new;

    // Slot under examination: payload comes from the registered read
    assign slot_v  = valid_reg[idx_reg];
    assign age     = now_reg - slot_stamp_reg;
    assign aged    = age > {16'd0, max_age};
    assign mac_eq  = slot_v && (slot_mac_reg == req_reg.mac);
    assign bad_mac = req_reg.mac[40] || (req_reg.mac == 48'd0);
    assign m_aged  = (now_reg - m_stamp_reg) > {16'd0, max_age};

    assign learn_ok   = cmd.finish && (req_reg.command == mlt_pkg::CMD_LEARN) && !bad_mac;
    assign learn_move = learn_ok && match_reg && (m_port_reg != req_reg.port);
    assign learn_new  = learn_ok && !match_reg && free_reg;

    // Drop decision for flush and sweep
    always_comb
    begin
        drop = 1'b0;
        case (req_reg.command)
            mlt_pkg::CMD_FLUSH:
                drop = slot_v && (req_reg.port == mlt_pkg::PORT_ALL
                                  || slot_port_reg == req_reg.port);
            mlt_pkg::CMD_SWEEP:
                drop = slot_v && aged;
            default:
                drop = 1'b0;
        endcase
    end

    // Stop early once a lookup or learn finds its MAC
    assign stop_scan = mac_eq && (req_reg.command == mlt_pkg::CMD_LOOKUP
                                  || req_reg.command == mlt_pkg::CMD_LEARN);
    assign last_slot = (idx_reg == IW'(ENTRIES - 1));
    assign sts       = '{last: last_slot, stop: stop_scan};

    // Next slot to read: slot 0 on load or at the final slot, else the one after the scan index
    assign rd_addr = (cmd.load || last_slot) ? '0 : idx_reg + IW'(1);

    // Resolve the response
    always_comb
    begin
        rsp_next = '0;
        case (req_reg.command) inside
            mlt_pkg::CMD_LOOKUP:
            begin
                if (match_reg && !m_aged)
                begin
                    rsp_next.hit        = 1'b1;
                    rsp_next.found_port = m_port_reg;
                    rsp_next.learned_at = m_stamp_reg;
                end
            end
            mlt_pkg::CMD_LEARN:
            begin
                if (bad_mac)
                    rsp_next.status = mlt_pkg::ST_INVALID;
                else if (!match_reg && !free_reg)
                    rsp_next.status = mlt_pkg::ST_FULL;
            end
            mlt_pkg::CMD_FLUSH, mlt_pkg::CMD_SWEEP:
                rsp_next.removed = removed_reg;
            default:
                rsp_next = '0;
        endcase
    end

    // Scan state, counter, valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            now_reg     <= 32'd0;
            idx_reg     <= '0;
            match_reg   <= 1'b0;
            free_reg    <= 1'b0;
            removed_reg <= 7'd0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg     <= '0;
                match_reg   <= 1'b0;
                free_reg    <= 1'b0;
                removed_reg <= 7'd0;
            end
            if (cmd.tick)
                now_reg <= now_reg + 32'd1;
            if (cmd.step)
            begin
                if (!last_slot)
                    idx_reg <= idx_reg + IW'(1);
                if (mac_eq && !match_reg)
                    match_reg <= 1'b1;
                if (!slot_v && !free_reg)
                    free_reg <= 1'b1;
                if (drop)
                begin
                    valid_reg[idx_reg] <= 1'b0;
                    if (removed_reg != mlt_pkg::REMOVED_MAX)
                        removed_reg <= removed_reg + 7'd1;
                end
            end
            if (learn_new)
                valid_reg[free_idx_reg] <= 1'b1;
        end
    end

    // Payload capture, registered slot read and slot writes
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.load || cmd.step)
        begin
            slot_mac_reg   <= mac_mem[rd_addr];
            slot_port_reg  <= port_mem[rd_addr];
            slot_stamp_reg <= stamp_mem[rd_addr];
        end
        if (cmd.step)
        begin
            if (mac_eq && !match_reg)
            begin
                match_idx_reg <= idx_reg;
                m_port_reg    <= slot_port_reg;
                m_stamp_reg   <= slot_stamp_reg;
            end
            if (!slot_v && !free_reg)
                free_idx_reg <= idx_reg;
        end
        if (learn_move)
        begin
            port_mem[match_idx_reg]  <= req_reg.port;
            stamp_mem[match_idx_reg] <= now_reg;
        end
        else if (learn_new)
        begin
            mac_mem[free_idx_reg]   <= req_reg.mac;
            port_mem[free_idx_reg]  <= req_reg.port;
            stamp_mem[free_idx_reg] <= now_reg;
        end
        if (cmd.finish)
            rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

/* hdl/mac_learning_table.sv */
// MAC learning table with aging: top level joining controller, datapath
// and APB register. Depends on mlt_pkg, mlt_ctrl, mlt_dp.
//
// Usage: requests enter on in_valid/in_ready with a command, MAC and port;
// exactly one response leaves on out_valid/out_ready per request.
// One request is handled at a time. The accepting edge captures the request
// and reads slot 0; the walk then examines one slot per cycle, and the
// resolve state writes back and registers the response. Lookup and learn
// stop the walk at the matching slot; flush, sweep, tick and unknown
// commands walk all slots. A new request is taken only once the response
// to the last one has been accepted. The response is registered; while the
// receiver stalls it holds and no new request is taken. Reset clears all
// valid bits, the seconds counter and the response flag at once; max_age
// returns to 300. The max_age register is to be written over the APB port
// only while the block is idle; the block itself does not enforce this.
module mac_learning_table
#(
    parameter int ENTRIES = mlt_pkg::DEFAULT_ENTRIES
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mlt_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output mlt_pkg::rsp_t out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    mlt_pkg::dp_cmd_t cmd;
    mlt_pkg::dp_sts_t sts;
    logic [15:0]      max_age_reg;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_age_reg <= mlt_pkg::MAX_AGE_RESET;
        else if (psel && penable && pwrite && paddr == mlt_pkg::REG_MAX_AGE)
            max_age_reg <= pwdata[15:0];
    end
    assign prdata = (paddr == mlt_pkg::REG_MAX_AGE) ? {16'd0, max_age_reg} : 32'd0;

    mlt_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_command (in_data.command),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    mlt_dp #(.ENTRIES(ENTRIES)) u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (in_data),
        .max_age (max_age_reg),
        .cmd     (cmd),
        .sts     (sts),
        .rsp     (out_data)
    );

endmodule

/* hdl/mlt_checker.sv */
// Port-level checker for the MAC learning table, bound to the top level.
// Depends on mlt_pkg.
module mlt_port_checks
(
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input mlt_pkg::req_t in_data,
    input logic          out_valid,
    input logic          out_ready,
    input mlt_pkg::rsp_t out_data
);

    // No new request while a response waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while response pending");

    // Response held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("response changed under stall");

    // A hit carries ok status and no removal count
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |-> out_data.status == mlt_pkg::ST_OK
                                     && out_data.removed == 7'd0)
        else $error("hit with stray fields");

    // Miss reports zero port and zero learned_at
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.found_port == 32'd0
                                      && out_data.learned_at == 32'd0)
        else $error("miss with nonzero port");

endmodule

bind mac_learning_table mlt_port_checks u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
